/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the lattice site index RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checked on every clock edge outside reset.
`define EOLSI_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// Checked on every clock edge, reset included.
`define EOLSI_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define EOLSI_ASSERT(lbl, prop, msg)
`define EOLSI_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

/* hw/rtl/eolsi_pkg.sv */
// Package with types, constants and helpers of the lattice site index unit.
`default_nettype none
package eolsi_pkg;

	localparam int IDX_W        = 28;
	localparam int CRD_W        = 7;
	localparam int EXT_W        = 8;
	localparam int VOL_W        = 32;
	localparam int CFG_IDX_W    = 3;
	localparam int DIMS         = 4;
	localparam int FRONT_STAGES = 5;
	localparam int DIV_STEP_DEF = 4;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_LAYOUT = 3'd0,
		CFG_EXT_X  = 3'd1,
		CFG_EXT_Y  = 3'd2,
		CFG_EXT_Z  = 3'd3,
		CFG_EXT_T  = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic             cb;
		logic [EXT_W-1:0] ext_x;
		logic [EXT_W-1:0] ext_y;
		logic [EXT_W-1:0] ext_z;
		logic [EXT_W-1:0] ext_t;
	} cfg_t;

	// Result of the front end: index path finished, decode path prepared.
	typedef struct packed {
		logic             op;
		logic             bad;
		logic [IDX_W-1:0] idx;
		logic             half;
		logic [IDX_W-1:0] site_rem;
	} front_t;

	// Item data that rides along the divider chain.
	typedef struct packed {
		logic             op;
		logic             bad;
		logic [IDX_W-1:0] idx;
		logic             half;
		logic [EXT_W-1:0] c0;
		logic [EXT_W-1:0] c1;
	} flow_t;

	// Extent of dimension 0 as the storage layout sees it.
	function automatic logic [EXT_W-1:0] eff_ext_x(input cfg_t c);
		return c.cb ? (c.ext_x >> 1) : c.ext_x;
	endfunction

endpackage
`default_nettype wire

/* hw/rtl/even_odd_lattice_site_index.sv */
// Top level of the even/odd lattice site index unit.
//
//   Channel   Handshake                 Payload
//   request   start, busy               op, in_coord_x..t, in_site_index
//   result    done (one-cycle strobe)   out_site_index, out_coord_x..t, out_of_range
//   config    cfg_valid, cfg_ready      cfg_index, cfg_data
//
// A request transaction is taken at every edge with start high; busy stays low, so
// one transaction per clock is sustained. Each result passes the front-end stages, the
// three chained pipelined dividers of the decode path and the output register.
// Reset clears all valid bits and the configuration registers (lexicographic
// layout, all extents 4). The receiver cannot stall, so the pipeline never holds.
`default_nettype none
`include "assert_macros.svh"
module even_odd_lattice_site_index
	import eolsi_pkg::*;
#(
	parameter int DIV_STEP = DIV_STEP_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	output logic                      busy,
	input  wire logic                 op,
	input  wire logic [CRD_W-1:0]     in_coord_x,
	input  wire logic [CRD_W-1:0]     in_coord_y,
	input  wire logic [CRD_W-1:0]     in_coord_z,
	input  wire logic [CRD_W-1:0]     in_coord_t,
	input  wire logic [IDX_W-1:0]     in_site_index,
	output logic                      done,
	output logic [IDX_W-1:0]          out_site_index,
	output logic [CRD_W-1:0]          out_coord_x,
	output logic [CRD_W-1:0]          out_coord_y,
	output logic [CRD_W-1:0]          out_coord_z,
	output logic [CRD_W-1:0]          out_coord_t,
	output logic                      out_of_range,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [EXT_W-1:0]     cfg_data
);

	localparam int LAT = FRONT_STAGES + 3 * (IDX_W / DIV_STEP) + 1;

	cfg_t   cfg;
	logic   accept;
	logic   f_vld, v1, v2, v3;
	front_t front;
	flow_t  fl0, fl1, fl1m, fl2, fl2m, fl3;
	logic [IDX_W-1:0] q1, q2, q3;
	logic [EXT_W-1:0] r1, r2, r3;

	// The pipeline advances every cycle, so a request is never refused.
	assign busy   = 1'b0;
	assign accept = start && !busy;

	eolsi_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Front end: the whole coordinate-to-index path, the lattice volume, and for
	// index-to-coordinate the choice of the even or odd half-volume.
	eolsi_encode u_enc (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.in_vld        (accept),
		.op            (op),
		.in_coord_x    (in_coord_x),
		.in_coord_y    (in_coord_y),
		.in_coord_z    (in_coord_z),
		.in_coord_t    (in_coord_t),
		.in_site_index (in_site_index),
		.out_vld       (f_vld),
		.front         (front)
	);

	always_comb begin
		fl0.op   = front.op;
		fl0.bad  = front.bad;
		fl0.idx  = front.idx;
		fl0.half = front.half;
		fl0.c0   = '0;
		fl0.c1   = '0;
	end

	// Decode path: peel off one coordinate per divider, dimension 0 first.
	eolsi_div #(.W(IDX_W), .STEP(DIV_STEP), .SW($bits(flow_t))) u_div_x (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (f_vld),
		.num      (front.site_rem),
		.den      (eff_ext_x(cfg)),
		.side_in  (fl0),
		.out_vld  (v1),
		.quo      (q1),
		.rem      (r1),
		.side_out (fl1)
	);

	always_comb begin
		fl1m    = fl1;
		fl1m.c0 = r1;
	end

	eolsi_div #(.W(IDX_W), .STEP(DIV_STEP), .SW($bits(flow_t))) u_div_y (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (v1),
		.num      (q1),
		.den      (cfg.ext_y),
		.side_in  (fl1m),
		.out_vld  (v2),
		.quo      (q2),
		.rem      (r2),
		.side_out (fl2)
	);

	always_comb begin
		fl2m    = fl2;
		fl2m.c1 = r2;
	end

	eolsi_div #(.W(IDX_W), .STEP(DIV_STEP), .SW($bits(flow_t))) u_div_z (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (v2),
		.num      (q2),
		.den      (cfg.ext_z),
		.side_in  (fl2m),
		.out_vld  (v3),
		.quo      (q3),
		.rem      (r3),
		.side_out (fl3)
	);

	// The last quotient is the dimension 3 coordinate, since the index is below the
	// volume. In checkerboard order coordinate 0 is doubled and its low bit restores
	// the parity of the chosen half-volume.
	logic             par_f, bad_f;
	logic [EXT_W:0]   cx_f;
	logic             done_q, oor_q;
	logic [IDX_W-1:0] idx_q;
	logic [CRD_W-1:0] cx_q, cy_q, cz_q, ct_q;

	always_comb begin
		par_f = fl3.half ^ fl3.c1[0] ^ r3[0] ^ q3[0];
		cx_f  = cfg.cb ? {fl3.c0, par_f} : {1'b0, fl3.c0};
		bad_f = fl3.bad || (fl3.op && ((|cx_f[EXT_W:CRD_W]) || fl3.c1[CRD_W]
			|| r3[CRD_W] || (|q3[IDX_W-1:CRD_W])));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= v3;
		end
	end

	always_ff @(posedge clk) begin
		oor_q <= bad_f;
		idx_q <= (bad_f || fl3.op) ? '0 : fl3.idx;
		cx_q  <= (bad_f || !fl3.op) ? '0 : cx_f[CRD_W-1:0];
		cy_q  <= (bad_f || !fl3.op) ? '0 : fl3.c1[CRD_W-1:0];
		cz_q  <= (bad_f || !fl3.op) ? '0 : r3[CRD_W-1:0];
		ct_q  <= (bad_f || !fl3.op) ? '0 : q3[CRD_W-1:0];
	end

	assign done           = done_q;
	assign out_of_range   = oor_q;
	assign out_site_index = idx_q;
	assign out_coord_x    = cx_q;
	assign out_coord_y    = cy_q;
	assign out_coord_z    = cz_q;
	assign out_coord_t    = ct_q;

	`EOLSI_ASSERT(a_latency, accept |-> ##LAT done, "accepted request gave no result in time")
	`EOLSI_ASSERT(a_no_phantom, done |-> $past(accept, LAT), "result without a request")
	`EOLSI_ASSERT(a_bad_zero, (done && out_of_range) |-> (out_site_index == '0 && out_coord_x == '0 && out_coord_y == '0 && out_coord_z == '0 && out_coord_t == '0), "flagged result is not zero")
	`EOLSI_ASSERT(a_one_kind, (done && out_site_index != '0) |-> (out_coord_x == '0 && out_coord_y == '0 && out_coord_z == '0 && out_coord_t == '0), "index and coordinates both set")
	`EOLSI_ASSERT_ALWAYS(a_reset_quiet, !arst_n |=> !done, "result strobe during reset")

endmodule
`default_nettype wire

/* hw/rtl/eolsi_cfg_regs.sv */
// Configuration register file of the lattice site index unit.
`default_nettype none
module eolsi_cfg_regs
	import eolsi_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [EXT_W-1:0]     cfg_data,
	output cfg_t                      cfg
);

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cb    <= 1'b0;
			cfg_q.ext_x <= EXT_W'(4);
			cfg_q.ext_y <= EXT_W'(4);
			cfg_q.ext_z <= EXT_W'(4);
			cfg_q.ext_t <= EXT_W'(4);
		end else if (cfg_valid) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_LAYOUT: begin
					cfg_q.cb <= cfg_data[0];
				end
				CFG_EXT_X: begin
					cfg_q.ext_x <= cfg_data;
				end
				CFG_EXT_Y: begin
					cfg_q.ext_y <= cfg_data;
				end
				CFG_EXT_Z: begin
					cfg_q.ext_z <= cfg_data;
				end
				CFG_EXT_T: begin
					cfg_q.ext_t <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

endmodule
`default_nettype wire

/* hw/rtl/eolsi_encode.sv */
// Front-end pipeline: coordinate to index, lattice volume and range checks.
`default_nettype none
module eolsi_encode
	import eolsi_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire cfg_t             cfg,
	input  wire logic             in_vld,
	input  wire logic             op,
	input  wire logic [CRD_W-1:0] in_coord_x,
	input  wire logic [CRD_W-1:0] in_coord_y,
	input  wire logic [CRD_W-1:0] in_coord_z,
	input  wire logic [CRD_W-1:0] in_coord_t,
	input  wire logic [IDX_W-1:0] in_site_index,
	output logic                  out_vld,
	output front_t                front
);

	// Stage 1: captured request.
	logic             vld_s1, op_s1;
	logic [CRD_W-1:0] cx_s1, cy_s1, cz_s1, ct_s1;
	logic [IDX_W-1:0] site_s1;

	// Stage 2.
	logic             vld_s2, op_s2, extbad_s2, crdbad_s2, par_s2;
	logic [CRD_W-1:0] cx_s2, cy_s2;
	logic [IDX_W-1:0] site_s2;
	logic [15:0]      acc_s2, p01_s2;

	// Stage 3.
	logic             vld_s3, op_s3, extbad_s3, crdbad_s3, par_s3;
	logic [CRD_W-1:0] cx_s3;
	logic [IDX_W-1:0] site_s3;
	logic [23:0]      acc_s3, p012_s3;

	// Stage 4.
	logic             vld_s4, op_s4, extbad_s4, crdbad_s4, par_s4;
	logic [IDX_W-1:0] site_s4;
	logic [VOL_W-1:0] acc_s4, vol_s4;

	// Stage 5: front-end result.
	logic   vld_s5;
	front_t front_s5;

	logic             extbad_a, crdbad_a, par_a;
	logic [15:0]      acc_a, p01_a;
	logic [23:0]      acc_b, p012_b;
	logic [EXT_W-1:0] exe_c;
	logic [CRD_W-1:0] cxe_c;
	logic [VOL_W-1:0] acc_c, vol_c;
	logic [VOL_W-1:0] vol_cb_d, site_d;
	logic [VOL_W:0]   idx_d;
	logic             idxbad_d, sitebad_d, half_d;
	front_t           front_d;

	always_comb begin
		extbad_a = (cfg.ext_x == '0) || (cfg.ext_y == '0) || (cfg.ext_z == '0)
			|| (cfg.ext_t == '0) || (cfg.cb && cfg.ext_x[0]);
		crdbad_a = ({1'b0, cx_s1} >= cfg.ext_x) || ({1'b0, cy_s1} >= cfg.ext_y)
			|| ({1'b0, cz_s1} >= cfg.ext_z) || ({1'b0, ct_s1} >= cfg.ext_t);
		par_a    = cx_s1[0] ^ cy_s1[0] ^ cz_s1[0] ^ ct_s1[0];
		acc_a    = 16'(ct_s1) * 16'(cfg.ext_z) + 16'(cz_s1);
		p01_a    = 16'(cfg.ext_x) * 16'(cfg.ext_y);
	end

	always_comb begin
		acc_b  = 24'(acc_s2) * 24'(cfg.ext_y) + 24'(cy_s2);
		p012_b = 24'(p01_s2) * 24'(cfg.ext_z);
	end

	always_comb begin
		exe_c = eff_ext_x(cfg);
		cxe_c = cfg.cb ? (cx_s3 >> 1) : cx_s3;
		acc_c = VOL_W'(acc_s3) * VOL_W'(exe_c) + VOL_W'(cxe_c);
		vol_c = VOL_W'(p012_s3) * VOL_W'(cfg.ext_t);
	end

	always_comb begin
		vol_cb_d  = vol_s4 >> 1;
		site_d    = VOL_W'(site_s4);
		idx_d     = (VOL_W+1)'(acc_s4)
			+ ((cfg.cb && par_s4) ? (VOL_W+1)'(vol_cb_d) : '0);
		idxbad_d  = |idx_d[VOL_W:IDX_W];
		sitebad_d = site_d >= vol_s4;
		half_d    = cfg.cb && (site_d >= vol_cb_d);
		front_d.op       = op_s4;
		front_d.bad      = extbad_s4 || (op_s4 ? sitebad_d : (crdbad_s4 || idxbad_d));
		front_d.idx      = idx_d[IDX_W-1:0];
		front_d.half     = half_d;
		front_d.site_rem = half_d ? (site_s4 - vol_cb_d[IDX_W-1:0]) : site_s4;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		op_s1     <= op;
		cx_s1     <= in_coord_x;
		cy_s1     <= in_coord_y;
		cz_s1     <= in_coord_z;
		ct_s1     <= in_coord_t;
		site_s1   <= in_site_index;

		op_s2     <= op_s1;
		extbad_s2 <= extbad_a;
		crdbad_s2 <= crdbad_a;
		par_s2    <= par_a;
		cx_s2     <= cx_s1;
		cy_s2     <= cy_s1;
		site_s2   <= site_s1;
		acc_s2    <= acc_a;
		p01_s2    <= p01_a;

		op_s3     <= op_s2;
		extbad_s3 <= extbad_s2;
		crdbad_s3 <= crdbad_s2;
		par_s3    <= par_s2;
		cx_s3     <= cx_s2;
		site_s3   <= site_s2;
		acc_s3    <= acc_b;
		p012_s3   <= p012_b;

		op_s4     <= op_s3;
		extbad_s4 <= extbad_s3;
		crdbad_s4 <= crdbad_s3;
		par_s4    <= par_s3;
		site_s4   <= site_s3;
		acc_s4    <= acc_c;
		vol_s4    <= vol_c;

		front_s5  <= front_d;
	end

	assign out_vld = vld_s5;
	assign front   = front_s5;

endmodule
`default_nettype wire

/* hw/rtl/eolsi_div.sv */
// Pipelined restoring divider by a narrow divisor, with data carried alongside.
`default_nettype none
module eolsi_div
	import eolsi_pkg::*;
#(
	parameter int W    = IDX_W,
	parameter int STEP = DIV_STEP_DEF,
	parameter int SW   = 1
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_vld,
	input  wire logic [W-1:0]     num,
	input  wire logic [EXT_W-1:0] den,
	input  wire logic [SW-1:0]    side_in,
	output logic                  out_vld,
	output logic [W-1:0]          quo,
	output logic [EXT_W-1:0]      rem,
	output logic [SW-1:0]         side_out
);

	// STEP must divide W; each stage retires STEP quotient bits.
	localparam int NST = W / STEP;

	logic             vld_s  [1:NST];
	logic [W-1:0]     num_s  [1:NST];
	logic [EXT_W-1:0] rem_s  [1:NST];
	logic [SW-1:0]    side_s [1:NST];

	for (genvar k = 0; k < NST; k++) begin : g_stage
		logic             v_in;
		logic [W-1:0]     n_in;
		logic [EXT_W-1:0] r_in;
		logic [SW-1:0]    sd_in;
		logic [W-1:0]     n_nx;
		logic [EXT_W-1:0] r_nx;

		if (k == 0) begin : g_first
			assign v_in  = in_vld;
			assign n_in  = num;
			assign r_in  = '0;
			assign sd_in = side_in;
		end else begin : g_next
			assign v_in  = vld_s[k];
			assign n_in  = num_s[k];
			assign r_in  = rem_s[k];
			assign sd_in = side_s[k];
		end

		always_comb begin
			logic [EXT_W:0] t;
			n_nx = n_in;
			r_nx = r_in;
			for (int i = 0; i < STEP; i++) begin
				t    = {r_nx, n_nx[W-1]};
				n_nx = {n_nx[W-2:0], 1'b0};
				if (t >= {1'b0, den}) begin
					t       = t - {1'b0, den};
					n_nx[0] = 1'b1;
				end
				r_nx = t[EXT_W-1:0];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else begin
				vld_s[k+1] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			num_s[k+1]  <= n_nx;
			rem_s[k+1]  <= r_nx;
			side_s[k+1] <= sd_in;
		end
	end

	assign out_vld  = vld_s[NST];
	assign quo      = num_s[NST];
	assign rem      = rem_s[NST];
	assign side_out = side_s[NST];

endmodule
`default_nettype wire
